>>> hw/rtl/rde_pkg.sv
// ----------------------------------------------------------------------------
// rde_pkg
// Shared types, constants and helpers of the radix digit emitter.
// ----------------------------------------------------------------------------
`default_nettype none

package rde_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int STEP_BITS       = 8;   // quotient bits resolved per divider cycle
  localparam int DIGIT_W         = 4;
  localparam int RADIX_W         = 5;
  localparam int CHAR_W          = 7;
  localparam int IN_DATA_W       = 72;  // value (64) + radix (5), padded to bytes
  localparam int OUT_DATA_W      = 8;   // digit_char (7), padded to a byte
  localparam int VALUE_FIELD_W   = 64;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_READ,
    ST_SHOW
  } rde_state_t;

  typedef struct packed {
    logic load;  // start a new value
    logic cont;  // divide the held quotient once more
  } rde_div_ctl_t;

  typedef struct packed {
    logic               done;    // remainder of this pass is ready
    logic               q_zero;  // quotient after this pass is zero
    logic [DIGIT_W-1:0] digit;
  } rde_div_sts_t;

  function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] res;
    res = r;
    if (r < RADIX_MIN) begin
      res = RADIX_MIN;
    end else if (r > RADIX_MAX) begin
      res = RADIX_MAX;
    end
    return res;
  endfunction

  // lower-case ascii glyph of a digit
  function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DIGIT_W'(10)) begin
      c = CHAR_W'(8'h30) + CHAR_W'(d);
    end else begin
      c = CHAR_W'(8'h61) + CHAR_W'(d) - CHAR_W'(10);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/rde_divider.sv
// ----------------------------------------------------------------------------
// rde_divider
// Iterative divide by a small base: STEP_BITS quotient bits per cycle,
// one remainder digit per pass over the quotient register.
// ----------------------------------------------------------------------------
`default_nettype none

module rde_divider
  import rde_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire rde_div_ctl_t           ctl,
  input  wire logic [VALUE_WIDTH-1:0] value,
  input  wire logic [RADIX_W-1:0]     base,
  output rde_div_sts_t                sts
);

  localparam int CHUNKS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
  localparam int QW     = CHUNKS * STEP_BITS;
  localparam int CW     = $clog2(CHUNKS + 1);

  logic [QW-1:0]        q;
  logic [DIGIT_W-1:0]   rem;
  logic [RADIX_W-1:0]   base_r;
  logic [CW-1:0]        cnt;
  logic                 busy;

  logic [STEP_BITS-1:0] top_bits;
  logic [STEP_BITS-1:0] qbits;
  logic [DIGIT_W-1:0]   rem_next;
  logic [QW-1:0]        q_next;
  logic                 last_chunk;

  assign top_bits = q[QW-1 -: STEP_BITS];

  // restoring division over the top chunk, remainder stays below the base
  always_comb begin
    logic [DIGIT_W:0] t;
    logic [DIGIT_W-1:0] r;
    r = rem;
    qbits = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      t = {r, top_bits[i]};
      if (t >= base_r) begin
        t = t - base_r;
        qbits[i] = 1'b1;
      end
      r = t[DIGIT_W-1:0];
    end
    rem_next = r;
  end

  assign q_next     = (q << STEP_BITS) | QW'(qbits);
  assign last_chunk = busy && (cnt == CW'(1));

  assign sts.done   = last_chunk;
  assign sts.q_zero = (q_next == '0);
  assign sts.digit  = rem_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (ctl.load) begin
      busy <= 1'b1;
      cnt  <= CW'(CHUNKS);
    end else if (busy) begin
      if (last_chunk) begin
        if (ctl.cont) begin
          cnt <= CW'(CHUNKS);
        end else begin
          busy <= 1'b0;
        end
      end else begin
        cnt <= cnt - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      q      <= QW'(value);
      base_r <= base;
      rem    <= '0;
    end else if (busy) begin
      q   <= q_next;
      rem <= last_chunk ? '0 : rem_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/radix_digit_emitter.sv
// ----------------------------------------------------------------------------
// radix_digit_emitter
// Converts an unsigned value into ascii digits of base 2..16, emitted most
// significant first with tlast on the final digit.
// ----------------------------------------------------------------------------
// division: D passes of the divider, D = digit count (1 for zero), each pass run by
//   the shared divider that resolves 8 quotient bits per cycle
// then each digit is read from the digit store, then shown until the output takes it
// input: a new item is taken only in the idle state, after the final digit of the
//   last one has been accepted; no new item is taken while one is in flight
// reset: sync active-high rst returns to idle; digit store needs no clearing
`default_nettype none

module radix_digit_emitter
  import rde_pkg::*;
#(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // value [63:0], radix [68:64]
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // digit_char [6:0]
  output logic                       m_axis_tlast
);

  localparam int DEPTH = VALUE_WIDTH;
  localparam int AW    = $clog2(DEPTH);
  localparam int NW    = $clog2(DEPTH + 1);

  rde_state_t state, state_next;

  rde_div_ctl_t div_ctl;
  rde_div_sts_t div_sts;

  logic [DIGIT_W-1:0] digit_store [DEPTH];
  logic [DIGIT_W-1:0] rd_data;
  logic [NW-1:0]      count;
  logic [AW-1:0]      rd_ptr;

  logic in_fire;
  logic out_fire;
  logic more_digits;
  logic [RADIX_W-1:0] radix_in;

  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign out_fire = m_axis_tvalid && m_axis_tready;
  assign radix_in = clamp_radix(s_axis_tdata[VALUE_FIELD_W +: RADIX_W]);

  // another pass only while quotient is nonzero and the store has room
  assign more_digits = !div_sts.q_zero && (count < NW'(DEPTH - 1));

  rde_divider #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .ctl  (div_ctl),
    .value(s_axis_tdata[VALUE_WIDTH-1:0]),
    .base (radix_in),
    .sts  (div_sts)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_fire) state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        if (div_sts.done && !more_digits) state_next = ST_READ;
      end
      ST_READ: begin
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_fire) state_next = (rd_ptr == '0) ? ST_IDLE : ST_READ;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    div_ctl       = '0;
    unique case (state)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        div_ctl.load  = s_axis_tvalid;
      end
      ST_DIVIDE: begin
        div_ctl.cont = div_sts.done && more_digits;
      end
      ST_READ: begin
      end
      ST_SHOW: begin
        m_axis_tvalid = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tdata = OUT_DATA_W'(glyph(rd_data));
  assign m_axis_tlast = (rd_ptr == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      count  <= '0;
      rd_ptr <= '0;
    end else begin
      state <= state_next;
      if (in_fire) begin
        count <= '0;
      end else if (state == ST_DIVIDE && div_sts.done) begin
        count <= count + NW'(1);
        if (!more_digits) rd_ptr <= count[AW-1:0];
      end else if (state == ST_SHOW && out_fire && rd_ptr != '0) begin
        rd_ptr <= rd_ptr - AW'(1);
      end
    end
  end

  // digit store, least significant digit at index 0
  always_ff @(posedge clk) begin
    if (state == ST_DIVIDE && div_sts.done) begin
      digit_store[count[AW-1:0]] <= div_sts.digit;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      rd_data <= digit_store[rd_ptr];
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready)
    else $error("output item shown while input is open");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= NW'(DEPTH))
    else $error("digit count beyond store depth");

  a_done_in_divide: assert property (@(posedge clk) disable iff (rst)
    div_sts.done |-> state == ST_DIVIDE)
    else $error("divider finished outside divide phase");

  a_idle_after_last: assert property (@(posedge clk) disable iff (rst)
    (out_fire && m_axis_tlast) |=> s_axis_tready)
    else $error("not ready after final digit");

endmodule

`default_nettype wire

>>> tb/digit_checker.sv
// ----------------------------------------------------------------------------
// digit_checker
// Watches both stream channels of the radix digit emitter. Each accepted
// number is converted into its expected digit characters. Each accepted
// output item is compared against the oldest expected digit.
// ----------------------------------------------------------------------------
`default_nettype none

module digit_checker
  import rde_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  s_axis_tvalid,
  input  wire logic                  s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // value [63:0], radix [68:64]
  input  wire logic                  m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  input  wire logic [OUT_DATA_W-1:0] m_axis_tdata,   // digit_char [6:0]
  input  wire logic                  m_axis_tlast,
  output int                         errors,
  output int                         owed
);

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] VALUE_MASK = {64{1'b1}} >> (64 - VALUE_WIDTH_DEF);

  typedef struct packed {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } digit_t;

  digit_t digits_due[$];

  initial begin
    errors = 0;
    owed = 0;
  end

  task automatic log_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    errors++;
  endtask

  // repeated division, remainders least significant first, then pushed
  // out most significant first
  function automatic void predict_digits(input logic [63:0] v, input logic [4:0] r);
    logic [63:0] q;
    logic [63:0] b;
    logic [3:0]  rems [64];
    int          n;
    digit_t      d;
    b = 64'(r);
    if (r < RADIX_MIN) begin
      b = 64'(RADIX_MIN);
    end else if (r > RADIX_MAX) begin
      b = 64'(RADIX_MAX);
    end
    q = v & VALUE_MASK;
    n = 0;
    do begin
      rems[n] = 4'(q % b);
      q = q / b;
      n++;
    end while (q != 0 && n < 64);
    for (int k = n - 1; k >= 0; k--) begin
      if (rems[k] < 4'd10) begin
        d.ch = 7'd48 + 7'(rems[k]);
      end else begin
        d.ch = 7'd87 + 7'(rems[k]);
      end
      d.last = (k == 0);
      digits_due.push_back(d);
    end
  endfunction

  always @(posedge clk) begin
    digit_t d;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        predict_digits(s_axis_tdata[63:0], s_axis_tdata[68:64]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (digits_due.size() == 0) begin
          log_mismatch($sformatf("unexpected digit item 0x%02h last=%0b",
                                 m_axis_tdata, m_axis_tlast));
        end else begin
          d = digits_due.pop_front();
          if (m_axis_tdata[CHAR_W-1:0] !== d.ch) begin
            log_mismatch($sformatf("digit_char 0x%02h, expected 0x%02h",
                                   m_axis_tdata[CHAR_W-1:0], d.ch));
          end
          if (m_axis_tlast !== d.last) begin
            log_mismatch($sformatf("last_digit %0b, expected %0b", m_axis_tlast, d.last));
          end
        end
      end
    end
    owed <= digits_due.size();
  end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives numbers and bases into the radix digit emitter and gives the
// verdict. Directed numbers cover zero, the widest values, clamped bases and
// power-of-base boundaries; random numbers follow, with random gaps on both
// sides, a long output hold-off and a drain pause.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench
  import rde_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_RANDOM = 350;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;    // value [63:0], radix [68:64]
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;    // digit_char [6:0]
  logic                  m_axis_tlast;

  int   errors;
  int   owed;
  logic in_fire;
  logic calm_in;

  radix_digit_emitter dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  digit_checker checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .errors        (errors),
    .owed          (owed)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  always @(posedge clk) begin
    in_fire <= s_axis_tvalid && s_axis_tready && !rst;
  end

  // offer one number; random gaps unless in the calm stretch
  task automatic offer_number(input logic [63:0] v, input logic [4:0] r);
    while (!calm_in && $urandom_range(0, 99) < 21) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, r, v};
    @(negedge clk);
    while (!in_fire) @(negedge clk);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk);
    while (owed != 0) @(negedge clk);
  endtask

  // receiver: random stalls, one long hold-off, one stretch always ready
  initial begin
    int cyc;
    int hold;
    m_axis_tready = 1'b0;
    cyc = 0;
    hold = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc == 3000) hold = 600;
      if (hold > 0) begin
        hold--;
        m_axis_tready <= 1'b0;
      end else if (cyc >= 9000 && cyc < 15000) begin
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= 21);
      end
    end
  end

  initial begin
    #30_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  initial begin
    logic [63:0] v;
    logic [63:0] p;
    logic [4:0]  r;
    int          guard;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    calm_in = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // zero value, including clamped bases
    offer_number(64'd0, 5'd10);
    offer_number(64'd0, 5'd0);
    offer_number(64'd0, 5'd1);
    // widest values, then 255 in a clamped base, one, and the top bit alone
    offer_number({64{1'b1}}, 5'd2);
    offer_number({64{1'b1}}, 5'd16);
    offer_number({64{1'b1}}, 5'd31);
    offer_number({64{1'b1}}, 5'd10);
    offer_number(64'd255, 5'd17);
    offer_number(64'd1, 5'd2);
    offer_number(64'h8000_0000_0000_0000, 5'd2);
    // largest power of each base from 3 to 15, or one below it
    for (int b = 3; b <= 15; b++) begin
      p = 64'(b);
      while (p <= {64{1'b1}} / 64'(b)) p = p * 64'(b);
      offer_number((b % 2 == 0) ? p : p - 64'd1, 5'(b));
    end
    wait_drained();

    for (int i = 0; i < NUM_RANDOM; i++) begin
      calm_in = (i >= 150 && i < 210);
      case ($urandom_range(0, 9))
        0:       v = 64'($urandom_range(0, 20));
        8, 9:    v = {$urandom, $urandom};
        default: v = {$urandom, $urandom} >> $urandom_range(0, 63);
      endcase
      if ($urandom_range(0, 9) == 0) begin
        r = 5'($urandom_range(0, 31));
      end else begin
        r = 5'($urandom_range(2, 16));
      end
      offer_number(v, r);
      if (i == 175) wait_drained();
    end
    s_axis_tvalid <= 1'b0;

    guard = 0;
    while (owed != 0 && guard < 500000) begin
      @(negedge clk);
      guard++;
    end
    repeat (300) @(negedge clk);
    if (errors == 0 && owed == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
